// ===== design/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants for the servo and motor command framer
// Holds the payload structs of both channels, the frame descriptor that
// travels from the classifier to the sequencer, and the bus command bytes.
// ----------------------------------------------------------------------------
package msc_pkg;

	// Function codes of an incoming command.
	localparam logic [1:0] FUNC_SERVO = 2'd0;
	localparam logic [1:0] FUNC_MOTOR = 2'd1;
	localparam logic [1:0] FUNC_LIGHT = 2'd2;

	// Light groups.
	localparam logic [1:0] LGT_FRONT   = 2'd0;
	localparam logic [1:0] LGT_AMBIENT = 2'd1;
	localparam logic [1:0] LGT_REAR    = 2'd2;

	// Bus symbol codes.
	localparam logic [1:0] SYM_START  = 2'd0;
	localparam logic [1:0] SYM_DATA   = 2'd1;
	localparam logic [1:0] SYM_STOP   = 2'd2;
	localparam logic [1:0] SYM_REJECT = 2'd3;

	// Frame kinds handled by the sequencer.
	localparam logic [1:0] FRM_MODE   = 2'd0;
	localparam logic [1:0] FRM_SERVO  = 2'd1;
	localparam logic [1:0] FRM_MOTOR  = 2'd2;
	localparam logic [1:0] FRM_REJECT = 2'd3;

	// Configuration register indexes.
	localparam logic [7:0] REG_BUS_ADDR  = 8'd0;
	localparam logic [7:0] REG_SERVO_MIN = 8'd1;
	localparam logic [7:0] REG_SERVO_MAX = 8'd2;
	localparam logic [7:0] REG_MOTOR_MAX = 8'd3;

	// Register reset values.
	localparam logic [7:0]  RST_BUS_ADDR  = 8'h80;
	localparam logic [15:0] RST_SERVO_MIN = 16'd50;
	localparam logic [15:0] RST_SERVO_MAX = 16'd250;
	localparam logic [15:0] RST_MOTOR_MAX = 16'd1000;

	// Command bytes.
	localparam logic [3:0][7:0] SERVO_CMD = {8'h2B, 8'h28, 8'h25, 8'h22};
	localparam logic [3:0][7:0] MOTOR_CMD = {8'h11, 8'h0D, 8'h09, 8'h05};
	localparam logic [7:0] MODE_BYTE      = 8'h00;
	localparam logic [7:0] MOTOR_SETUP    = 8'h01;
	localparam logic [7:0] FRONT_ON       = 8'h2D;
	localparam logic [7:0] FRONT_OFF      = 8'h2E;
	localparam logic [7:0] AMBIENT_ON     = 8'h36;
	localparam logic [7:0] AMBIENT_OFF    = 8'h37;
	localparam logic [7:0] REAR_A_ON      = 8'h30;
	localparam logic [7:0] REAR_A_OFF     = 8'h31;
	localparam logic [7:0] REAR_B_ON      = 8'h33;
	localparam logic [7:0] REAR_B_OFF     = 8'h34;

	// A command expands into at most this many frames.
	localparam int FRAMES = 4;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  channel;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic [1:0]  light_group;
		logic        light_on;
	} cmd_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic [7:0] data_byte;
		logic       last;
	} sym_t;

	typedef struct packed {
		logic [7:0]  bus_address_byte;
		logic [15:0] servo_pulse_min;
		logic [15:0] servo_pulse_max;
		logic [15:0] motor_value_max;
	} cfg_t;

	// One classified command: a list of frames and the values they carry.
	typedef struct packed {
		logic [FRAMES-1:0][1:0] frm_kind;
		logic [FRAMES-1:0][7:0] frm_cmd;
		logic [1:0]             last_frm;
		logic [15:0]            value_a;
		logic [15:0]            value_b;
	} desc_t;

endpackage

// ===== design/msc_front.sv =====
// ----------------------------------------------------------------------------
// msc_front: command classifier
// Checks each accepted command against the limits and turns it into a frame
// descriptor for the queue. Tracks whether the motor init frame was sent.
// ----------------------------------------------------------------------------
module msc_front import msc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_stall,
	input  cmd_t  cmd,
	input  cfg_t  cfg,
	input  logic  q_full,
	output logic  push,
	output desc_t push_desc
);

	logic       motor_primed_q;
	logic       ch_ok;
	logic [1:0] ch_idx;
	logic       servo_ok;
	logic       motor_ok;
	logic [7:0] servo_c;
	logic [7:0] motor_c;

	assign cmd_stall = q_full;
	assign push      = cmd_valid && !q_full;

	// Channel and limit checks.
	assign ch_ok    = (cmd.channel >= 8'd1) && (cmd.channel <= 8'd4);
	assign ch_idx   = cmd.channel[1:0] - 2'd1;
	assign servo_c  = SERVO_CMD[ch_idx];
	assign motor_c  = MOTOR_CMD[ch_idx];
	assign servo_ok = (cmd.func == FUNC_SERVO) && ch_ok
		&& (cmd.value_a >= cfg.servo_pulse_min)
		&& (cmd.value_a <= cfg.servo_pulse_max);
	assign motor_ok = (cmd.func == FUNC_MOTOR) && ch_ok
		&& (cmd.value_a <= cfg.motor_value_max)
		&& (cmd.value_b <= cfg.motor_value_max);

	// Build the frame list in the order the frames go out on the bus.
	always_comb begin
		push_desc          = '0;
		push_desc.value_a  = cmd.value_a;
		push_desc.value_b  = cmd.value_b;
		push_desc.frm_kind = {FRAMES{FRM_REJECT}};
		push_desc.last_frm = 2'd0;
		priority if (servo_ok) begin
			push_desc.frm_kind[0] = FRM_MODE;
			push_desc.frm_cmd[0]  = servo_c;
			push_desc.frm_kind[1] = FRM_SERVO;
			push_desc.frm_cmd[1]  = servo_c;
			push_desc.last_frm    = 2'd1;
		end else if (motor_ok && !motor_primed_q) begin
			push_desc.frm_kind[0] = FRM_MODE;
			push_desc.frm_cmd[0]  = MOTOR_SETUP;
			push_desc.frm_kind[1] = FRM_MODE;
			push_desc.frm_cmd[1]  = motor_c;
			push_desc.frm_kind[2] = FRM_MOTOR;
			push_desc.frm_cmd[2]  = motor_c;
			push_desc.last_frm    = 2'd2;
		end else if (motor_ok) begin
			push_desc.frm_kind[0] = FRM_MODE;
			push_desc.frm_cmd[0]  = motor_c;
			push_desc.frm_kind[1] = FRM_MOTOR;
			push_desc.frm_cmd[1]  = motor_c;
			push_desc.last_frm    = 2'd1;
		end else if (cmd.func == FUNC_LIGHT && cmd.light_group == LGT_FRONT) begin
			push_desc.frm_kind[0] = FRM_MODE;
			push_desc.frm_cmd[0]  = cmd.light_on ? FRONT_ON : FRONT_OFF;
		end else if (cmd.func == FUNC_LIGHT && cmd.light_group == LGT_AMBIENT) begin
			push_desc.frm_kind[0] = FRM_MODE;
			push_desc.frm_cmd[0]  = cmd.light_on ? AMBIENT_ON : AMBIENT_OFF;
		end else if (cmd.func == FUNC_LIGHT && cmd.light_group == LGT_REAR) begin
			push_desc.frm_kind[0] = FRM_MODE;
			push_desc.frm_cmd[0]  = cmd.light_on ? REAR_A_ON : REAR_A_OFF;
			push_desc.frm_kind[1] = FRM_MODE;
			push_desc.frm_cmd[1]  = cmd.light_on ? REAR_B_ON : REAR_B_OFF;
			push_desc.last_frm    = 2'd1;
		end else begin
			// Rejected command: a single reject frame.
			push_desc.frm_kind[0] = FRM_REJECT;
		end
	end

	// The init frame goes out once, with the first accepted motor command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_primed_q <= 1'b0;
		end else if (push && motor_ok) begin
			motor_primed_q <= 1'b1;
		end
	end

endmodule

// ===== design/msc_queue.sv =====
// ----------------------------------------------------------------------------
// msc_queue: descriptor queue
// A short register FIFO between the classifier and the sequencer so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module msc_queue import msc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output desc_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/msc_back.sv =====
// ----------------------------------------------------------------------------
// msc_back: symbol sequencer
// Walks the frames of the descriptor at the queue head and emits one bus
// symbol per cycle, unless sym_stall holds the output, into an output register.
// ----------------------------------------------------------------------------
module msc_back import msc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       not_empty,
	input  desc_t      head,
	output logic       pop,
	input  logic [7:0] bus_address_byte,
	output logic       sym_valid,
	input  logic       sym_stall,
	output sym_t       sym
);

	logic [1:0] frm_q;
	logic [2:0] pos_q;
	logic       out_valid_q;
	sym_t       out_q;

	logic       adv;
	logic [1:0] kind;
	logic [7:0] cbyte;
	logic [1:0] nsym;
	logic [7:0] nbyte;
	logic       eof;
	logic       last;

	assign kind  = head.frm_kind[frm_q];
	assign cbyte = head.frm_cmd[frm_q];

	// Advance whenever work is waiting and the output register can move.
	assign adv  = not_empty && (!out_valid_q || !sym_stall);
	assign last = eof && (frm_q == head.last_frm);
	assign pop  = adv && last;

	// Symbol for the current position of the current frame.
	always_comb begin
		nsym  = SYM_DATA;
		nbyte = 8'h00;
		eof   = 1'b0;
		if (kind == FRM_REJECT) begin
			nsym = SYM_REJECT;
			eof  = 1'b1;
		end else if (pos_q == 3'd0) begin
			nsym = SYM_START;
		end else if (pos_q == 3'd1) begin
			nbyte = bus_address_byte;
		end else begin
			unique case (kind)
				FRM_MODE: begin
					unique case (pos_q)
						3'd2: nbyte = MODE_BYTE;
						3'd3: nbyte = cbyte;
						default: begin
							nsym = SYM_STOP;
							eof  = 1'b1;
						end
					endcase
				end
				FRM_SERVO: begin
					unique case (pos_q)
						3'd2: nbyte = cbyte;
						3'd3: nbyte = head.value_a[15:8];
						3'd4: nbyte = head.value_a[7:0];
						default: begin
							nsym = SYM_STOP;
							eof  = 1'b1;
						end
					endcase
				end
				default: begin
					unique case (pos_q)
						3'd2: nbyte = cbyte;
						3'd3: nbyte = head.value_a[15:8];
						3'd4: nbyte = head.value_a[7:0];
						3'd5: nbyte = head.value_b[15:8];
						3'd6: nbyte = head.value_b[7:0];
						default: begin
							nsym = SYM_STOP;
							eof  = 1'b1;
						end
					endcase
				end
			endcase
		end
	end

	// Frame and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_q <= '0;
			pos_q <= '0;
		end else if (adv) begin
			if (last) begin
				frm_q <= '0;
				pos_q <= '0;
			end else if (eof) begin
				frm_q <= frm_q + 2'd1;
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!sym_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.symbol    <= nsym;
			out_q.data_byte <= nbyte;
			out_q.last      <= last;
		end
	end

	assign sym_valid = out_valid_q;
	assign sym       = out_q;

endmodule

// ===== design/motor_servo_command_framer.sv =====
// ----------------------------------------------------------------------------
// motor_servo_command_framer: command to bus symbol framer
// Takes servo, motor and light commands for an I2C servo and motor board and
// turns each one into START, data byte and STOP symbols, or a REJECT symbol.
//
// Usage:
// - Command channel (cmd_valid, cmd_stall, cmd): a transfer takes place at a
//   clock edge with cmd_valid high and cmd_stall low.
// - Symbol channel (sym_valid, sym_stall, sym): one symbol per transfer;
//   sym.last marks the final symbol of a command's run.
// - Register port (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; indexes above 3 are ignored. Write only while idle.
// - Start: a command's descriptor goes into the queue at its transfer, and when
//   the sequencer is free its first symbol moves to the output register.
// - Throughput: one symbol per cycle unless stalled; a command is 1 to 18
//   symbols (reject 1, light 5 or 10, servo 11, motor 13, 18 with init frame).
//   The symbol sequencer sets the rate; a QUEUE_DEPTH descriptor queue
//   lets new commands be taken while earlier runs are still going out.
// - Reset clears the queue, the output register and the motor init flag, and
//   loads the register defaults.
// - While the receiver stalls, the current symbol holds; once the queue is
//   full, cmd_stall rises.
// ----------------------------------------------------------------------------
module motor_servo_command_framer import msc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2  // range 2 and up
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        sym_valid,
	input  logic        sym_stall,
	output sym_t        sym,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  push;
	desc_t push_desc;
	logic  pop;
	logic  not_empty;
	desc_t head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_address_byte <= RST_BUS_ADDR;
			cfg_q.servo_pulse_min  <= RST_SERVO_MIN;
			cfg_q.servo_pulse_max  <= RST_SERVO_MAX;
			cfg_q.motor_value_max  <= RST_MOTOR_MAX;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BUS_ADDR) begin
				cfg_q.bus_address_byte <= cfg_data[7:0];
			end
			if (cfg_index == REG_SERVO_MIN) begin
				cfg_q.servo_pulse_min <= cfg_data;
			end
			if (cfg_index == REG_SERVO_MAX) begin
				cfg_q.servo_pulse_max <= cfg_data;
			end
			if (cfg_index == REG_MOTOR_MAX) begin
				cfg_q.motor_value_max <= cfg_data;
			end
		end
	end

	msc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	msc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	msc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.not_empty        (not_empty),
		.head             (head),
		.pop              (pop),
		.bus_address_byte (cfg_q.bus_address_byte),
		.sym_valid        (sym_valid),
		.sym_stall        (sym_stall),
		.sym              (sym)
	);

endmodule
